>>> rtl/core/hcx_pkg.sv
// ----------------------------------------------------------------------------
// hcx_pkg
// Shared types, constants and byte-order helpers for the hash-chain cipher.
// ----------------------------------------------------------------------------
package hcx_pkg;

  // keystream geometry
  localparam int unsigned CHAIN_BYTES = 32;
  localparam int unsigned CHAIN_W     = 8 * CHAIN_BYTES;
  localparam int unsigned KEY_WORDS   = 4;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned RND_W       = 6;

  // sha-256 round constants
  localparam logic [31:0] K_ROUND [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // sha-256 initial hash value
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // padding words of a single 256-bit message block
  localparam logic [31:0] PAD_FIRST = 32'h8000_0000;
  localparam logic [31:0] PAD_LEN   = 32'd256;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_EMIT
  } hcx_state_e;

  // request to the round unit
  typedef struct packed {
    logic start;
  } hcx_ctrl_t;

  // status of the round unit
  typedef struct packed {
    logic busy;
    logic done;
  } hcx_stat_t;

  function automatic logic [31:0] rotr32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // big-endian message word i from chain bytes 4i..4i+3
  function automatic logic [31:0] chain_word(logic [CHAIN_W-1:0] c, int unsigned i);
    return {c[8*(4*i)+:8], c[8*(4*i+1)+:8], c[8*(4*i+2)+:8], c[8*(4*i+3)+:8]};
  endfunction

  // digest words (word j in bits 32j+31:32j) back to chain byte order
  function automatic logic [CHAIN_W-1:0] digest_to_chain(logic [CHAIN_W-1:0] dig);
    logic [CHAIN_W-1:0] c;
    c = '0;
    for (int unsigned n = 0; n < CHAIN_BYTES; n++) begin
      c[8*n+:8] = dig[32*(n/4) + 24 - 8*(n%4) +: 8];
    end
    return c;
  endfunction

endpackage

>>> rtl/core/hash_chain_xor_stream_cipher_unit.sv
// Timing: a byte that uses the current chain value reaches the output register in the
// cycle after it is taken; a byte that needs a fresh chain value waits for one load,
// the 64 rounds of the single sha-256 round unit, one chain update and one emit.
// Throughput: one byte a cycle inside a 32-byte chain value while the output is not
// stalled; no new byte is taken while a fresh chain value is hashed. Reset clears
// the key, chain value and byte position to zero and empties the output register.
// ----------------------------------------------------------------------------
// hash_chain_xor_stream_cipher_unit
// Byte-stream xor cipher whose keystream is a sha-256 hash chain on the key.
// ----------------------------------------------------------------------------
module hash_chain_xor_stream_cipher_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // key registers
  input  logic                          cfg_we_i,
  input  logic [hcx_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hcx_pkg::KEY_W-1:0]     cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // last_byte
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] out_byte
  output logic                          m_axis_tlast   // out_last
);
  import hcx_pkg::*;

  logic [KEY_W-1:0]   key_q [KEY_WORDS];
  logic [CHAIN_W-1:0] key_flat, key_new;
  logic [CHAIN_W-1:0] chain_q;
  logic [POS_W-1:0]   pos_q;
  hcx_state_e         state_q, state_d;
  logic               ov_q, ov_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               out_last_q, out_last_d;
  logic [7:0]         pend_data_q;
  logic               pend_last_q;

  logic               key_set, out_free, accept, load_out, step_pos, restart, cfg_hit;
  logic [7:0]         ks_byte;
  hcx_ctrl_t          core_ctrl;
  hcx_stat_t          core_stat;
  logic [CHAIN_W-1:0] digest;

  // key as one flat word, and with a pending write merged in
  always_comb begin
    for (int unsigned i = 0; i < KEY_WORDS; i++) begin
      key_flat[KEY_W*i+:KEY_W] = key_q[i];
      key_new[KEY_W*i+:KEY_W]  = (cfg_idx_i == CFG_IDX_W'(i)) ? cfg_data_i : key_q[i];
    end
  end

  assign cfg_hit  = cfg_we_i && (cfg_idx_i < CFG_IDX_W'(KEY_WORDS));
  assign key_set  = |key_flat;
  assign out_free = !ov_q || m_axis_tready;
  assign ks_byte  = key_set ? chain_q[{pos_q[POS_W-2:0], 3'b000}+:8] : 8'h00;
  assign accept   = s_axis_tvalid && s_axis_tready;

  // sequencer
  always_comb begin
    state_d         = state_q;
    s_axis_tready   = 1'b0;
    core_ctrl.start = 1'b0;
    load_out        = 1'b0;
    step_pos        = 1'b0;
    restart         = 1'b0;
    out_byte_d      = out_byte_q;
    out_last_d      = out_last_q;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = out_free && !core_stat.busy;
        if (accept) begin
          if (key_set && pos_q[POS_W-1]) begin
            core_ctrl.start = 1'b1;
            state_d         = ST_HASH;
          end else begin
            load_out   = 1'b1;
            out_byte_d = s_axis_tdata ^ ks_byte;
            out_last_d = s_axis_tlast;
            step_pos   = key_set;
            restart    = s_axis_tlast;
          end
        end
      end
      ST_HASH: begin
        if (core_stat.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_byte_d = pend_data_q ^ ks_byte;
          out_last_d = pend_last_q;
          step_pos   = 1'b1;
          restart    = pend_last_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    ov_d = ov_q;
    if (load_out) begin
      ov_d = 1'b1;
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end
  end

  // control state, key and chain value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      pos_q   <= '0;
      chain_q <= '0;
      for (int unsigned i = 0; i < KEY_WORDS; i++) begin
        key_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      if (cfg_hit) begin
        key_q[cfg_idx_i[1:0]] <= cfg_data_i;
        chain_q               <= key_new;
        pos_q                 <= '0;
      end else if (restart) begin
        chain_q <= key_flat;
        pos_q   <= '0;
      end else if (state_q == ST_HASH && core_stat.done) begin
        chain_q <= digest_to_chain(digest);
        pos_q   <= '0;
      end else if (step_pos) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    if (accept) begin
      pend_data_q <= s_axis_tdata;
      pend_last_q <= s_axis_tlast;
    end
  end

  // sha-256 round unit
  hcx_sha_core u_sha (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (core_ctrl),
    .block_i  (chain_q),
    .status_o (core_stat),
    .digest_o (digest)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> rtl/core/hcx_sha_core.sv
// ----------------------------------------------------------------------------
// hcx_sha_core
// One sha-256 round per cycle over a single padded 256-bit block, with a
// rolling 16-word message schedule.
// ----------------------------------------------------------------------------
module hcx_sha_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hcx_pkg::hcx_ctrl_t          ctrl_i,
  input  logic [hcx_pkg::CHAIN_W-1:0] block_i,
  output hcx_pkg::hcx_stat_t          status_o,
  output logic [hcx_pkg::CHAIN_W-1:0] digest_o
);
  import hcx_pkg::*;

  logic [31:0]      w_q [16];
  logic [31:0]      w_d [16];
  logic [31:0]      st_q [8];
  logic [31:0]      st_d [8];
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [31:0] t1, t2, s0, s1, w_new;

  // round datapath
  always_comb begin
    t1 = st_q[7] + (rotr32(st_q[4], 6) ^ rotr32(st_q[4], 11) ^ rotr32(st_q[4], 25))
       + ((st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6])) + K_ROUND[rnd_q] + w_q[0];
    t2 = (rotr32(st_q[0], 2) ^ rotr32(st_q[0], 13) ^ rotr32(st_q[0], 22))
       + ((st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]));
    s0 = rotr32(w_q[1], 7) ^ rotr32(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr32(w_q[14], 17) ^ rotr32(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
  end

  // load, step and finish
  always_comb begin
    w_d    = w_q;
    st_d   = st_q;
    rnd_d  = rnd_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      for (int unsigned i = 0; i < 8; i++) begin
        w_d[i]  = chain_word(block_i, i);
        st_d[i] = H_INIT[i];
      end
      w_d[8] = PAD_FIRST;
      for (int unsigned i = 9; i < 15; i++) begin
        w_d[i] = '0;
      end
      w_d[15] = PAD_LEN;
      rnd_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      for (int unsigned i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = w_new;
      st_d[7] = st_q[6];
      st_d[6] = st_q[5];
      st_d[5] = st_q[4];
      st_d[4] = st_q[3] + t1;
      st_d[3] = st_q[2];
      st_d[2] = st_q[1];
      st_d[1] = st_q[0];
      st_d[0] = t1 + t2;
      rnd_d   = rnd_q + 1'b1;
      if (rnd_q == RND_W'(ROUNDS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      rnd_q  <= rnd_d;
    end
  end

  // schedule and working variables
  always_ff @(posedge clk_i) begin
    w_q  <= w_d;
    st_q <= st_d;
  end

  // final feed-forward add
  always_comb begin
    for (int unsigned j = 0; j < 8; j++) begin
      digest_o[32*j+:32] = H_INIT[j] + st_q[j];
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

>>> rtl/core/hcx_checker.sv
// ----------------------------------------------------------------------------
// hcx_checker
// Port-level checks on the cipher unit: one byte in flight, tlast carried
// through, stalled results held.
// ----------------------------------------------------------------------------
module hcx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic in_acc, out_acc;
  logic pend_q;
  logic pend_last_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // track the single request in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      if (in_acc) begin
        pend_q      <= 1'b1;
        pend_last_q <= s_axis_tlast;
      end else if (out_acc) begin
        pend_q <= 1'b0;
      end
    end
  end

  // no result without a request behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q)
    else $error("result delivered with no request in flight");

  // a new request only while the previous result leaves
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && pend_q) |-> out_acc)
    else $error("request taken while a result is still owed");

  // tlast follows its request
  a_last_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (m_axis_tlast == pend_last_q))
    else $error("tlast of result differs from its request");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind hash_chain_xor_stream_cipher_unit hcx_checker u_hcx_checker (.*);

>>> dv/hcx_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcx_stream_checker
// Watches the key port and both streams of the hash-chain cipher, keeps its
// own keystream model and compares every output request with the prediction.
// ----------------------------------------------------------------------------
module hcx_stream_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hcx_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hcx_pkg::KEY_W-1:0]     cfg_data_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [7:0]                    s_tdata_i,
  input  logic                          s_tlast_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [7:0]                    m_tdata_i,
  input  logic                          m_tlast_i,
  output int                            outstanding_o,
  output int                            fail_count_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  // sha-256 round constants
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // sha-256 initial hash value
  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last;
  } cipher_out_t;

  logic [hcx_pkg::KEY_W-1:0]   key_q [hcx_pkg::KEY_WORDS];
  logic [hcx_pkg::CHAIN_W-1:0] keystream_q;
  int unsigned                 ks_pos_q;
  cipher_out_t                 expected_cipher_q [$];
  int                          fail_cnt;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    logic [63:0] xx;
    xx = {x, x} >> n;
    return xx[31:0];
  endfunction

  // sha-256 of the 32 chain bytes as one padded block, digest in chain byte order
  function automatic logic [hcx_pkg::CHAIN_W-1:0] chain_digest(
      logic [hcx_pkg::CHAIN_W-1:0] cv);
    logic [31:0]                 w [64];
    logic [31:0]                 st [8];
    logic [31:0]                 t1, t2, s0, s1, hw;
    logic [hcx_pkg::CHAIN_W-1:0] nxt;
    for (int i = 0; i < 8; i++) begin
      w[i] = {cv[32*i +: 8], cv[32*i+8 +: 8], cv[32*i+16 +: 8], cv[32*i+24 +: 8]};
    end
    w[8] = 32'h8000_0000;
    for (int i = 9; i < 15; i++) begin
      w[i] = '0;
    end
    w[15] = 32'd256;
    for (int i = 16; i < 64; i++) begin
      s0   = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1   = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    st = SHA_IV;
    for (int i = 0; i < 64; i++) begin
      t1 = st[7] + (ror32(st[4], 6) ^ ror32(st[4], 11) ^ ror32(st[4], 25))
         + ((st[4] & st[5]) ^ (~st[4] & st[6])) + SHA_K[i] + w[i];
      t2 = (ror32(st[0], 2) ^ ror32(st[0], 13) ^ ror32(st[0], 22))
         + ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
      st[7] = st[6];
      st[6] = st[5];
      st[5] = st[4];
      st[4] = st[3] + t1;
      st[3] = st[2];
      st[2] = st[1];
      st[1] = st[0];
      st[0] = t1 + t2;
    end
    // digest bytes in big-endian word order become chain bytes 0..31
    for (int n = 0; n < 32; n++) begin
      hw = SHA_IV[n/4] + st[n/4];
      nxt[8*n +: 8] = hw[24 - 8*(n%4) +: 8];
    end
    return nxt;
  endfunction

  function automatic void restart_keystream();
    for (int i = 0; i < hcx_pkg::KEY_WORDS; i++) begin
      keystream_q[hcx_pkg::KEY_W*i +: hcx_pkg::KEY_W] = key_q[i];
    end
    ks_pos_q = 0;
  endfunction

  // expected output for one accepted input request
  function automatic cipher_out_t encrypt_byte(logic [7:0] data, logic last);
    cipher_out_t res;
    logic        key_set;
    key_set = 1'b0;
    for (int i = 0; i < hcx_pkg::KEY_WORDS; i++) begin
      key_set |= (key_q[i] != '0);
    end
    res.cipher_byte = data;
    res.last        = last;
    // zero key passes the byte and leaves the chain where it is
    if (key_set) begin
      if (ks_pos_q >= hcx_pkg::CHAIN_BYTES) begin
        keystream_q = chain_digest(keystream_q);
        ks_pos_q    = 0;
      end
      res.cipher_byte = data ^ keystream_q[8*ks_pos_q +: 8];
      ks_pos_q++;
    end
    if (last) begin
      restart_keystream();
    end
    return res;
  endfunction

  // track key writes, compare results, queue predictions
  always @(posedge clk_i) begin
    cipher_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < hcx_pkg::KEY_WORDS; i++) begin
        key_q[i] = '0;
      end
      restart_keystream();
      expected_cipher_q.delete();
      fail_cnt = 0;
    end else begin
      // out-of-range index is ignored by the block
      if (cfg_we_i && cfg_idx_i < hcx_pkg::KEY_WORDS) begin
        key_q[cfg_idx_i] = cfg_data_i;
        restart_keystream();
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_cipher_q.size() == 0) begin
          if (fail_cnt < REPORT_LIMIT) begin
            $display("%0t: unexpected output byte %h last %b", $realtime,
                     m_tdata_i, m_tlast_i);
          end
          fail_cnt++;
        end else begin
          want = expected_cipher_q.pop_front();
          if (m_tdata_i !== want.cipher_byte || m_tlast_i !== want.last) begin
            if (fail_cnt < REPORT_LIMIT) begin
              $display("%0t: mismatch byte exp %h got %h, last exp %b got %b",
                       $realtime, want.cipher_byte, m_tdata_i, want.last, m_tlast_i);
            end
            fail_cnt++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_cipher_q.push_back(encrypt_byte(s_tdata_i, s_tlast_i));
      end
    end
    outstanding_o <= expected_cipher_q.size();
    fail_count_o  <= fail_cnt;
  end

endmodule

>>> dv/hash_chain_xor_stream_cipher_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_chain_xor_stream_cipher_unit_tb
// Drives key settings and byte messages into the cipher with random gaps on
// both streams; the checker predicts every output byte and counts failures.
// ----------------------------------------------------------------------------
module hash_chain_xor_stream_cipher_unit_tb;

  localparam int unsigned ITEM_TARGET    = 1450;
  localparam int unsigned MAX_GAP        = 8;
  localparam int unsigned HASH_LATENCY   = 66;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned PRESSURE_PHASE = 2;

  typedef logic [hcx_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  // key register indexes
  localparam logic [hcx_pkg::CFG_IDX_W-1:0] REG_KEY_WORD_0 = 0;
  localparam logic [hcx_pkg::CFG_IDX_W-1:0] REG_KEY_WORD_1 = 1;
  localparam logic [hcx_pkg::CFG_IDX_W-1:0] REG_KEY_WORD_2 = 2;
  localparam logic [hcx_pkg::CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3;
  localparam logic [hcx_pkg::CFG_IDX_W-1:0] REG_IDX_TOP    = '1;
  localparam logic [hcx_pkg::CFG_IDX_W-1:0] REG_KEY [4] = '{
    REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3
  };

  typedef enum int {
    KEY_ZERO,
    KEY_ONES,
    KEY_RANDOM,
    KEY_ONE_WORD,
    KEY_ONE_BIT,
    KEY_PARTIAL
  } key_mode_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [hcx_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [hcx_pkg::KEY_W-1:0]     cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;   // [7:0] data_byte
  logic                          s_axis_tlast;   // last_byte
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [7:0]                    m_axis_tdata;   // [7:0] out_byte
  logic                          m_axis_tlast;   // out_last

  int                            outstanding;
  int                            fail_count;
  int unsigned                   idle_cycles;
  bit                            burst_tx;
  logic [hcx_pkg::CFG_IDX_W-1:0] wr_idx_q [$];
  logic [hcx_pkg::KEY_W-1:0]     wr_val_q [$];

  hash_chain_xor_stream_cipher_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  hcx_stream_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tlast_i     (s_axis_tlast),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tlast_i     (m_axis_tlast),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watchdog on cycles without any request moving
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                 || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output side: random stalls with stretches of none
  initial begin
    int unsigned gap;
    int unsigned taken;
    bit          burst_rx;
    bit          hit;
    burst_rx = 1'b0;
    taken    = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken % 50 == 0) begin
        burst_rx = ($urandom_range(0, 3) == 0);
      end
      gap = burst_rx ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      // tvalid is settled by the falling edge and holds up to the next rising edge
      do begin
        @(negedge clk_i);
        hit = m_axis_tvalid;
        @(posedge clk_i);
      end while (!hit);
      taken++;
    end
  end

  function automatic logic [hcx_pkg::KEY_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void queue_write(logic [hcx_pkg::CFG_IDX_W-1:0] idx,
                                      logic [hcx_pkg::KEY_W-1:0] val);
    wr_idx_q.push_back(idx);
    wr_val_q.push_back(val);
  endfunction

  // one input request after a random gap
  task automatic send_byte(logic [7:0] data, logic last);
    int unsigned gap;
    bit          hit;
    gap = burst_tx ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    // tready is settled by the falling edge and holds up to the next rising edge
    do begin
      @(negedge clk_i);
      hit = s_axis_tready;
      @(posedge clk_i);
    end while (!hit);
  endtask

  // stop sending and wait for every predicted byte to come out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // key writes only once the block has gone quiet
  task automatic write_registers();
    settle();
    repeat (HASH_LATENCY + 8) @(posedge clk_i);
    while (wr_idx_q.size() != 0) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= wr_idx_q.pop_front();
      cfg_data_i <= wr_val_q.pop_front();
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic void queue_key(key_mode_e mode);
    int unsigned sel;
    sel = $urandom_range(0, 3);
    case (mode)
      KEY_ZERO: begin
        foreach (REG_KEY[i]) queue_write(REG_KEY[i], '0);
      end
      KEY_ONES: begin
        foreach (REG_KEY[i]) queue_write(REG_KEY[i], '1);
      end
      KEY_ONE_WORD: begin
        foreach (REG_KEY[i]) queue_write(REG_KEY[i], (i == sel) ? rand_word() : '0);
      end
      KEY_ONE_BIT: begin
        foreach (REG_KEY[i]) begin
          queue_write(REG_KEY[i], (i == sel) ? (64'd1 << $urandom_range(0, 63)) : '0);
        end
      end
      KEY_PARTIAL: begin
        queue_write(REG_KEY[sel], rand_word());
      end
      default: begin
        foreach (REG_KEY[i]) queue_write(REG_KEY[i], rand_word());
      end
    endcase
  endfunction

  // stimulus and verdict
  initial begin
    int unsigned total, phase, quota, sent, len;
    bit          noise;
    key_mode_e   mode;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    burst_tx      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero key after reset: bytes pass through
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b1);

    // all-ones key
    queue_key(KEY_ONES);
    write_registers();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h3c, 1'b1);

    // key change in mid-message restarts the keystream
    send_byte(8'h81, 1'b0);
    send_byte(8'h7e, 1'b0);
    queue_write(REG_KEY_WORD_2, 64'h0123_4567_89ab_cdef);
    write_registers();
    send_byte(8'h81, 1'b0);
    send_byte(8'h7e, 1'b1);

    // writes beyond the key words are ignored
    queue_write(cfg_idx_t'(hcx_pkg::KEY_WORDS), '1);
    queue_write(REG_IDX_TOP, rand_word());
    write_registers();
    send_byte(8'h12, 1'b0);
    send_byte(8'hed, 1'b1);

    // single set bit in the top word
    foreach (REG_KEY[i]) queue_write(REG_KEY[i], (i == 3) ? 64'h8000_0000_0000_0000 : '0);
    write_registers();
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hc3, 1'b1);

    // random phases: a key setting, then mostly whole messages
    total = 0;
    phase = 0;
    while (total < ITEM_TARGET) begin
      mode = key_mode_e'((phase == 0) ? KEY_RANDOM : $urandom_range(KEY_ZERO, KEY_PARTIAL));
      queue_key(mode);
      if ($urandom_range(0, 3) == 0) begin
        queue_write(cfg_idx_t'($urandom_range(hcx_pkg::KEY_WORDS, REG_IDX_TOP)),
                    rand_word());
      end
      write_registers();
      quota = $urandom_range(60, 140);
      sent  = 0;
      while (sent < quota) begin
        burst_tx = ($urandom_range(0, 3) == 0);
        noise    = ($urandom_range(0, 4) == 0);
        if (noise) begin
          len = $urandom_range(1, 50);
        end else if ($urandom_range(0, 4) == 0) begin
          len = $urandom_range(64, 130);
        end else begin
          len = $urandom_range(1, 40);
        end
        for (int b = 0; b < len && sent < quota; b++) begin
          send_byte(8'($urandom_range(0, 255)),
                    noise ? ($urandom_range(0, 7) == 0) : (b == len - 1));
          sent++;
          // hold the sender until the output side has caught up
          if (phase == PRESSURE_PHASE && sent == quota / 2) begin
            settle();
          end
        end
      end
      total += sent;
      phase++;
    end

    settle();
    repeat (HASH_LATENCY + 16) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/hcx_pkg.sv
rtl/core/hcx_sha_core.sv
rtl/core/hash_chain_xor_stream_cipher_unit.sv
rtl/core/hcx_checker.sv
dv/hcx_stream_checker.sv
dv/hash_chain_xor_stream_cipher_unit_tb.sv
